// ----- rtl/mtd_pkg.sv -----
// Package for the multi-input time debounce filter.
// Shared widths and fixed constants; no dependencies.
`default_nettype none

package mtd_pkg;

    localparam int DATA_W = 64;   // width of the raw and filtered sample ports
    localparam int TIME_W = 8;    // width of times, hold timers and hold setting

    localparam logic [TIME_W-1:0] TIMER_IDLE     = 8'hFF;
    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 8'd20;

endpackage

`default_nettype wire

// ----- rtl/mtd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
`default_nettype none

module mtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/multi_input_time_debounce.sv -----
// Top level of the multi-input time debounce filter.
// Depends on mtd_pkg (widths, constants) and mtd_ram (hold timer store).
`default_nettype none

// Usage
//   Input channel (i_in_valid / o_in_ready): one transfer carries a raw sample
//   of all inputs (i_raw_bits, bit k is channel k) and the milliseconds since
//   the previous sample (i_elapsed_ms).
//   Output channel (o_out_valid / i_out_ready): one transfer per sample, with
//   the debounced state (o_filtered_bits) and o_changed, set if any channel
//   committed on that sample. Bits at and above CHANNELS are always 0.
//   Configuration: i_cfg_we writes i_cfg_wdata into the hold time at once;
//   write only while the filter is idle.
// Timing
//   The per-channel hold timers live in a RAM and are walked one channel per
//   cycle: read, update, write back. A sample moves from the input buffer
//   through the walk states S_SCAN, S_DRAIN and S_DONE into the output register.
//   A one-entry input buffer takes the next sample while a walk is running.
// Reset and stalls
//   Reset sets the hold time to 20 ms, clears committed and staged bits and
//   marks every timer as running at zero (per-entry valid bits, no clearing
//   pass). A stalled receiver holds the result; the next walk waits in its
//   final state until the output register is free.
module multi_input_time_debounce #(
    parameter int CHANNELS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [mtd_pkg::TIME_W-1:0]    i_cfg_wdata,
    // sample input
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mtd_pkg::DATA_W-1:0]    i_raw_bits,
    input  wire logic [mtd_pkg::TIME_W-1:0]    i_elapsed_ms,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [mtd_pkg::DATA_W-1:0]    o_filtered_bits,
    output logic                               o_changed
);

    import mtd_pkg::*;

    localparam int IDX_W = $clog2(CHANNELS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [TIME_W-1:0]   r_debounce_ms;

    // input buffer
    logic                r_in_full;
    logic [CHANNELS-1:0] r_in_raw;
    logic [TIME_W-1:0]   r_in_elapsed;

    // sample under work
    logic [CHANNELS-1:0] r_raw;
    logic [TIME_W-1:0]   r_elapsed;
    logic                r_chg;

    // per-channel state
    logic [CHANNELS-1:0] r_committed;
    logic [CHANNELS-1:0] r_staged;
    logic [CHANNELS-1:0] r_tvalid;    // timer entry written since reset

    // walk control
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_p1_valid;
    logic [IDX_W-1:0]    r_p1_idx;

    // output register
    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_bits;
    logic                r_out_chg;

    // RAM and update path
    logic                rd_en;
    logic [TIME_W-1:0]   rd_data;
    logic [TIME_W-1:0]   timer;
    logic [TIME_W:0]     sum;
    logic                cur_bit;
    logic                edge_seen;
    logic                commit_hit;
    logic [TIME_W-1:0]   n_timer;

    assign o_in_ready      = !r_in_full;
    assign o_out_valid     = r_out_valid;
    assign o_filtered_bits = DATA_W'(r_out_bits);
    assign o_changed       = r_out_chg;

    assign rd_en = (r_state == S_SCAN);

    mtd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CHANNELS)
    ) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (r_p1_valid),
        .i_waddr (r_p1_idx),
        .i_wdata (n_timer),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    // Channel update, one channel per cycle. Reads run one index ahead of
    // writes, so read and write never hit the same entry.
    always_comb begin
        cur_bit    = r_raw[r_p1_idx];
        timer      = r_tvalid[r_p1_idx] ? rd_data : '0;
        sum        = {1'b0, r_elapsed} + {1'b0, timer};
        edge_seen  = (r_staged[r_p1_idx] != cur_bit);
        commit_hit = 1'b0;
        if (edge_seen) begin
            // restart, or idle if the bit is back at its committed value
            n_timer = (r_committed[r_p1_idx] == cur_bit) ? TIMER_IDLE : '0;
        end else if (timer == TIMER_IDLE) begin
            n_timer = TIMER_IDLE;
        end else if ((r_elapsed >= r_debounce_ms) || (sum > {1'b0, r_debounce_ms})) begin
            n_timer    = TIMER_IDLE;
            commit_hit = 1'b1;
        end else begin
            n_timer = sum[TIME_W-1:0];  // sum <= hold time, fits
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_debounce_ms <= DEBOUNCE_RESET;
            r_in_full     <= 1'b0;
            r_chg         <= 1'b0;
            r_committed   <= '0;
            r_staged      <= '0;
            r_tvalid      <= '0;
            r_rd_idx      <= '0;
            r_p1_valid    <= 1'b0;
            r_p1_idx      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_debounce_ms <= i_cfg_wdata;
            end

            if (i_in_valid && o_in_ready) begin
                r_in_full    <= 1'b1;
                r_in_raw     <= i_raw_bits[CHANNELS-1:0];
                r_in_elapsed <= i_elapsed_ms;
            end

            // a result loaded in S_DONE takes the place of the one leaving
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            r_p1_valid <= rd_en;
            r_p1_idx   <= r_rd_idx;

            if (r_p1_valid) begin
                r_staged[r_p1_idx] <= cur_bit;
                r_tvalid[r_p1_idx] <= 1'b1;
                if (commit_hit) begin
                    r_committed[r_p1_idx] <= cur_bit;
                    r_chg                 <= 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (r_in_full) begin
                        r_raw     <= r_in_raw;
                        r_elapsed <= r_in_elapsed;
                        r_chg     <= 1'b0;
                        r_rd_idx  <= '0;
                        r_in_full <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_bits  <= r_committed;
                        r_out_chg   <= r_chg;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The update stage only runs inside a walk.
    a_p1_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("channel update outside a walk");

    // A finished walk has written every timer entry.
    a_walk_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (&r_tvalid))
        else $error("walk ended with unwritten timer entries");

    // A new result only appears at the end of a walk.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final walk state");

endmodule

`default_nettype wire
